@@ hdl/assert_macros.svh @@
// Assertion shorthands used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

@@ hdl/rhpm_pkg.sv @@
`timescale 1ns / 1ps

package rhpm_pkg;

  localparam int HISTORY_DEPTH = 40;
  // history entry 0 lives in the top level, the rest in the cell row
  localparam int CELLS = HISTORY_DEPTH - 1;
  localparam int DIV_STEPS = 32;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_STEPS - 1);
  localparam int WAIT_W = $clog2(HISTORY_DEPTH);
  localparam logic [WAIT_W-1:0] WAIT_LAST = WAIT_W'(CELLS);

  typedef struct packed {
    logic [31:0] sample_time;
    logic [63:0] counter_value;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] rate;
    logic signed [31:0] peak_rate;
    logic [5:0]         entry_count;
  } result_t;

  // history entry or partial maximum, with its valid flag
  typedef struct packed {
    logic               vld;
    logic signed [31:0] val;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PEAK
  } state_t;

endpackage

@@ hdl/rhpm_cell.sv @@
`timescale 1ns / 1ps

module rhpm_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  rhpm_pkg::entry_t entry_in,
  output rhpm_pkg::entry_t entry,
  input  rhpm_pkg::entry_t peak_in,
  output rhpm_pkg::entry_t peak
);

  logic               vld;
  logic signed [31:0] val;
  logic               pk_vld;
  logic signed [31:0] pk_val;
  logic               take_own;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (shift) begin
      vld <= entry_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      val <= entry_in.val;
    end
  end

  // running maximum moves one cell toward the head each cycle
  assign take_own = vld && (!peak_in.vld || (val > peak_in.val));

  always_ff @(posedge clk) begin
    if (rst) begin
      pk_vld <= 1'b0;
    end else begin
      pk_vld <= vld | peak_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    pk_val <= take_own ? val : peak_in.val;
  end

  assign entry = '{vld: vld, val: val};
  assign peak  = '{vld: pk_vld, val: pk_val};

endmodule

@@ hdl/rhpm_div.sv @@
`timescale 1ns / 1ps

module rhpm_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic signed [32:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic                             busy;
  logic                             fix;
  logic [rhpm_pkg::DIV_CNT_W-1:0]   cnt;
  logic [31:0]                      rem;
  logic [31:0]                      quo;
  logic [31:0]                      dvs;
  logic                             neg;
  logic [32:0]                      trial;
  logic [32:0]                      diff;
  logic                             ge;
  logic [32:0]                      dvs_abs;

  assign dvs_abs = divisor[32] ? (33'd0 - divisor) : divisor;

  // one quotient bit per cycle, restoring
  assign trial = {rem, quo[31]};
  assign diff  = trial - {1'b0, dvs};
  assign ge    = (trial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      // quotient is loaded in the fix cycle, done follows it
      done <= fix;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == rhpm_pkg::DIV_LAST) begin
          busy <= 1'b0;
          fix  <= 1'b1;
        end
      end else if (fix) begin
        fix <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend[31] ? (32'd0 - dividend) : dividend;
      dvs <= dvs_abs[31:0];
      neg <= dividend[31] ^ divisor[32];
    end else if (busy) begin
      rem <= ge ? diff[31:0] : trial[31:0];
      quo <= {quo[30:0], ge};
    end
    if (fix) begin
      quotient <= neg ? (32'd0 - quo) : quo;
    end
  end

endmodule

@@ hdl/rate_history_peak_monitor.sv @@
// channel | dir | handshake                    | word
// sample  | in  | sample_valid / sample_stall  | sample_time, counter_value
// result  | out | result_valid / result_stall  | rate, peak_rate, entry_count
//
// One word in flight: a new word is taken only after the result of the last
// one is written to the result register. The result waits for the flush of
// the running maximum through the history cell row; the serial divide runs
// under it. rst is synchronous and leaves one zero entry.
// A stalled result sits in its register while the next word is processed.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rate_history_peak_monitor (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_stall,
  input  rhpm_pkg::sample_t sample,
  output logic              result_valid,
  input  logic              result_stall,
  output rhpm_pkg::result_t result
);

  rhpm_pkg::state_t state;
  rhpm_pkg::state_t state_next;

  logic [31:0]                 last_time;
  logic [63:0]                 last_count;
  logic [31:0]                 running_diff;
  logic signed [31:0]          head_val;
  logic [5:0]                  fill;
  logic signed [31:0]          rate_r;
  logic                        is_new;
  logic                        div_ok;
  logic [rhpm_pkg::WAIT_W-1:0] cnt;

  logic               accept;
  logic               new_sec;
  logic               out_free;
  logic               shift;
  logic [31:0]        delta;
  logic [31:0]        same_sum;
  logic signed [32:0] elapsed;
  logic               div_done;
  logic signed [31:0] div_q;
  logic signed [31:0] peak_val;

  rhpm_pkg::entry_t cell_ent [rhpm_pkg::CELLS];
  rhpm_pkg::entry_t cell_pk  [rhpm_pkg::CELLS];

  assign accept   = sample_valid && !sample_stall;
  assign new_sec  = (sample.sample_time != last_time);
  assign out_free = !result_valid || !result_stall;
  assign shift    = accept && new_sec;
  assign delta    = sample.counter_value[31:0] - last_count[31:0];
  // delta counts only once history holds two or more entries
  assign same_sum = running_diff + (cell_ent[0].vld ? delta : 32'd0);
  assign elapsed  = $signed({1'b0, sample.sample_time}) - $signed({1'b0, last_time});

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rhpm_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    sample_stall = 1'b1;
    case (state)
      rhpm_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        if (sample_valid) begin
          state_next = rhpm_pkg::ST_RUN;
        end
      end
      rhpm_pkg::ST_RUN: begin
        if ((cnt == rhpm_pkg::WAIT_LAST) && (!is_new || div_ok)) begin
          state_next = rhpm_pkg::ST_PEAK;
        end
      end
      rhpm_pkg::ST_PEAK: begin
        if (out_free) begin
          state_next = rhpm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = rhpm_pkg::ST_IDLE;
      end
    endcase
  end

  rhpm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (shift),
    .dividend (delta),
    .divisor  (elapsed),
    .done     (div_done),
    .quotient (div_q)
  );

  for (genvar i = 0; i < rhpm_pkg::CELLS; i++) begin : g_cell
    rhpm_pkg::entry_t ent_in;
    rhpm_pkg::entry_t pk_in;
    if (i == 0) begin : g_first
      assign ent_in = '{vld: 1'b1, val: head_val};
    end else begin : g_mid
      assign ent_in = cell_ent[i-1];
    end
    if (i == rhpm_pkg::CELLS - 1) begin : g_last
      assign pk_in = '{vld: 1'b0, val: 32'sd0};
    end else begin : g_inner
      assign pk_in = cell_pk[i+1];
    end
    rhpm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (shift),
      .entry_in (ent_in),
      .entry    (cell_ent[i]),
      .peak_in  (pk_in),
      .peak     (cell_pk[i])
    );
  end

  assign peak_val = (cell_pk[0].vld && (cell_pk[0].val > rate_r)) ? cell_pk[0].val : rate_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_time    <= '0;
      last_count   <= '0;
      running_diff <= '0;
      head_val     <= '0;
      fill         <= 6'd1;
      is_new       <= 1'b0;
      div_ok       <= 1'b0;
      cnt          <= '0;
      result_valid <= 1'b0;
    end else begin
      if (accept) begin
        last_count <= sample.counter_value;
        is_new     <= new_sec;
        div_ok     <= 1'b0;
        cnt        <= '0;
        if (new_sec) begin
          last_time    <= sample.sample_time;
          running_diff <= delta;
          if (!cell_ent[rhpm_pkg::CELLS-1].vld) begin
            fill <= fill + 6'd1;
          end
        end else begin
          running_diff <= same_sum;
        end
      end
      if (state == rhpm_pkg::ST_RUN && cnt != rhpm_pkg::WAIT_LAST) begin
        cnt <= cnt + 1'b1;
      end
      if (div_done) begin
        div_ok <= 1'b1;
      end
      if (state == rhpm_pkg::ST_PEAK && out_free) begin
        head_val     <= rate_r;
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !new_sec) begin
      rate_r <= same_sum;
    end else if (div_done) begin
      rate_r <= div_q;
    end
    if (state == rhpm_pkg::ST_PEAK && out_free) begin
      result <= '{rate: rate_r, peak_rate: peak_val, entry_count: fill};
    end
  end

  `CHK_NEXT(a_accept_run, clk, rst, accept, state == rhpm_pkg::ST_RUN)
  `CHK_IMPL(a_div_in_run, clk, rst, div_done, state == rhpm_pkg::ST_RUN && is_new)
  `CHK_IMPL(a_out_from_peak, clk, rst, $rose(result_valid), $past(state == rhpm_pkg::ST_PEAK))
  `CHK_IMPL(a_hist_packed, clk, rst, cell_ent[rhpm_pkg::CELLS-1].vld, cell_ent[0].vld)

endmodule

@@ verif/rate_history_peak_monitor_tb.sv @@
`timescale 1ns / 1ps

module rate_history_peak_monitor_tb;

  localparam int RAND_ITEMS   = 1750;
  localparam int IDLE_LIMIT   = 5000;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 60;
  localparam int DIR_ROWS     = 25;

  typedef struct packed {
    logic [31:0] t;
    logic [63:0] c;
    logic        typed;
    logic [31:0] rate;
    logic [31:0] peak;
    logic [5:0]  cnt;
  } dir_row_t;

  typedef struct packed {
    rhpm_pkg::sample_t s;
    logic              typed;
    rhpm_pkg::result_t r;
  } plan_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              sample_valid = 1'b0;
  logic              sample_stall;
  rhpm_pkg::sample_t sample = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  rhpm_pkg::result_t result;

  // directed words; typed rows carry their expected result
  dir_row_t dir_rows [0:DIR_ROWS-1] = '{
    // first second after reset: history has one entry, delta ignored
    '{32'd0, 64'd123, 1'b1, 32'd0, 32'd0, 6'd1},
    '{32'd0, 64'd5000, 1'b1, 32'd0, 32'd0, 6'd1},
    '{32'd1, 64'd6000, 1'b1, 32'd1000, 32'd1000, 6'd2},
    // same second accumulates and replaces the newest entry
    '{32'd1, 64'd6500, 1'b1, 32'd1500, 32'd1500, 6'd2},
    // counter going down
    '{32'd3, 64'd2500, 1'b1, -32'sd2000, 32'd1500, 6'd3},
    // time going backwards, then truncation toward zero
    '{32'd2, 64'd3100, 1'b1, -32'sd600, 32'd1500, 6'd4},
    '{32'd0, 64'd3107, 1'b1, -32'sd3, 32'd1500, 6'd5},
    '{32'd5, 64'd3107, 1'b1, 32'd0, 32'd1500, 6'd6},
    // most negative over minus one wraps
    '{32'd4, 64'h0000_0000_8000_0C23, 1'b1, 32'h8000_0000, 32'd1500, 6'd7},
    // running sum wraps to zero
    '{32'd4, 64'h0000_0001_0000_0C23, 1'b1, 32'd0, 32'd1500, 6'd8 - 6'd1},
    '{32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 32'd0, 32'd1500, 6'd8},
    '{32'd0, 64'd0, 1'b1, 32'd0, 32'd1500, 6'd9},
    '{32'd1, 64'h0000_0000_7FFF_FFFF, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 6'd10},
    // replacing the peak entry drops the peak
    '{32'd1, 64'h0000_0000_8000_0000, 1'b1, 32'h8000_0000, 32'd1500, 6'd10},
    '{32'd2, 64'h0000_0000_8001_86A0, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd3, 64'h0000_0000_8003_0D40, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd3, 64'h0000_0000_8003_0D40, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd4, 64'h5555_5555_AAAA_AAAA, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd6, 64'hAAAA_AAAA_5555_5555, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd6, 64'hAAAA_AAAA_5555_6000, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd7, 64'h0000_0000_0000_0000, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd9, 64'hFFFF_FFFF_0000_0000, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd10, 64'hFFFF_FFFF_1000_0000, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd13, 64'h8000_0000_0000_0001, 1'b0, 32'd0, 32'd0, 6'd0},
    '{32'd14, 64'h8000_0000_0100_0001, 1'b0, 32'd0, 32'd0, 6'd0}
  };

  plan_t             sample_plan [$];
  rhpm_pkg::result_t pending_results [$];
  int                acc_idx = 0;
  int                results_seen = 0;
  int                errors = 0;
  int                idle_cycles = 0;
  int                tx_quiet = 0;
  int                rx_quiet = 0;
  bit                pressure_done = 1'b0;

  // predictor state
  logic [31:0]        prev_time;
  logic [63:0]        prev_count;
  logic [31:0]        sec_diff;
  logic signed [31:0] hist_rates [rhpm_pkg::HISTORY_DEPTH];
  int                 hist_fill;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  rate_history_peak_monitor dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  function automatic void reset_rate_state();
    prev_time  = '0;
    prev_count = '0;
    sec_diff   = '0;
    for (int i = 0; i < rhpm_pkg::HISTORY_DEPTH; i++) hist_rates[i] = '0;
    hist_fill = 1;
  endfunction

  function automatic rhpm_pkg::result_t compute_rate_result(rhpm_pkg::sample_t s);
    rhpm_pkg::result_t  r;
    logic [31:0]        delta;
    longint             num;
    longint             elapsed;
    longint             quo;
    logic signed [31:0] pk;
    delta = s.counter_value[31:0] - prev_count[31:0];
    if (s.sample_time == prev_time) begin
      if (hist_fill > 1) sec_diff = sec_diff + delta;
      r.rate = sec_diff;
      hist_rates[0] = sec_diff;
    end else begin
      // signed elapsed seconds, wide enough for backwards steps
      elapsed = longint'({32'd0, s.sample_time}) - longint'({32'd0, prev_time});
      sec_diff = delta;
      num = $signed(sec_diff);
      quo = num / elapsed;
      r.rate = quo[31:0];
      prev_time = s.sample_time;
      for (int i = rhpm_pkg::HISTORY_DEPTH - 1; i > 0; i--) hist_rates[i] = hist_rates[i-1];
      hist_rates[0] = r.rate;
      if (hist_fill < rhpm_pkg::HISTORY_DEPTH) hist_fill++;
    end
    prev_count = s.counter_value;
    pk = hist_rates[0];
    for (int i = 1; i < hist_fill; i++) begin
      if (hist_rates[i] > pk) pk = hist_rates[i];
    end
    r.peak_rate   = pk;
    r.entry_count = hist_fill[5:0];
    return r;
  endfunction

  function automatic int idle_len(inout int quiet);
    int k;
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    k = $urandom_range(0, 99);
    if (k < 2) begin
      quiet = $urandom_range(20, 120);
      return 0;
    end
    if (k < 60) return 0;
    if (k < 95) return $urandom_range(1, 4);
    return $urandom_range(20, 60);
  endfunction

  task automatic build_plan();
    plan_t       p;
    logic [31:0] gen_time;
    logic [63:0] gen_count;
    logic [63:0] delta;
    int          mode;
    int          k;
    foreach (dir_rows[i]) begin
      p.s.sample_time   = dir_rows[i].t;
      p.s.counter_value = dir_rows[i].c;
      p.typed           = dir_rows[i].typed;
      p.r.rate          = dir_rows[i].rate;
      p.r.peak_rate     = dir_rows[i].peak;
      p.r.entry_count   = dir_rows[i].cnt;
      sample_plan.push_back(p);
    end
    gen_time  = dir_rows[DIR_ROWS-1].t;
    gen_count = dir_rows[DIR_ROWS-1].c;
    p.typed = 1'b0;
    p.r     = '0;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      k = $urandom_range(0, 9);
      delta = (k < 7) ? 64'($urandom_range(0, 50000)) :
              (k < 9) ? 64'($urandom) : {$urandom, $urandom};
      mode = $urandom_range(0, 99);
      if (mode < 55) begin
        // next second, now and then a long jump
        gen_time += ($urandom_range(0, 19) == 0) ? $urandom_range(2, 1000) : 1;
        gen_count += delta;
      end else if (mode < 82) begin
        gen_count += delta;
      end else if (mode < 89) begin
        gen_count = {$urandom, $urandom};
      end else if (mode < 94) begin
        gen_time = $urandom;
      end else begin
        gen_time -= $urandom_range(1, 7);
        gen_count -= 64'($urandom_range(0, 1 << 20));
      end
      p.s.sample_time   = gen_time;
      p.s.counter_value = gen_count;
      sample_plan.push_back(p);
    end
  endtask

  // sender
  initial begin
    int gap;
    while (rst) @(posedge clk);
    foreach (sample_plan[i]) begin
      sample_valid <= 1'b1;
      sample       <= sample_plan[i].s;
      @(posedge clk);
      while (sample_stall) @(posedge clk);
      gap = idle_len(tx_quiet);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    sample_valid <= 1'b0;
  end

  // receiver; one long hold-off to back the block up
  initial begin
    int len;
    while (rst) @(posedge clk);
    forever begin
      if (!pressure_done && results_seen >= 300) begin
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        pressure_done = 1'b1;
      end else begin
        len = idle_len(rx_quiet);
        if (len > 0) begin
          result_stall <= 1'b1;
          repeat (len) @(posedge clk);
        end else begin
          result_stall <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
        end
      end
    end
  end

  // accepted input word -> expected result
  always @(posedge clk) begin
    rhpm_pkg::result_t r;
    if (!rst && sample_valid && !sample_stall) begin
      r = compute_rate_result(sample);
      if (sample_plan[acc_idx].typed) r = sample_plan[acc_idx].r;
      pending_results.push_back(r);
      acc_idx++;
    end
  end

  always @(posedge clk) begin
    rhpm_pkg::result_t want;
    if (!rst && result_valid && !result_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result word with none expected: rate %0d peak %0d count %0d",
                 $time, result.rate, result.peak_rate, result.entry_count);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (result.rate !== want.rate) begin
          $display("%0t: rate expected %0d got %0d", $time, want.rate, result.rate);
          errors++;
        end
        if (result.peak_rate !== want.peak_rate) begin
          $display("%0t: peak_rate expected %0d got %0d", $time, want.peak_rate,
                   result.peak_rate);
          errors++;
        end
        if (result.entry_count !== want.entry_count) begin
          $display("%0t: entry_count expected %0d got %0d", $time, want.entry_count,
                   result.entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_rate_state();
    build_plan();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (acc_idx < sample_plan.size() || pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hdl
hdl/rhpm_pkg.sv
hdl/rhpm_cell.sv
hdl/rhpm_div.sv
hdl/rate_history_peak_monitor.sv
verif/rate_history_peak_monitor_tb.sv
